// File: rtl/message_ring_queue_with_urgent_macros.svh
// assertion macros used by the checker file
`ifndef MESSAGE_RING_QUEUE_WITH_URGENT_MACROS_SVH
`define MESSAGE_RING_QUEUE_WITH_URGENT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MRQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define MRQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mrq_pkg.sv
`default_nettype none

package mrq_pkg;

   // request kinds
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_URGENT = 2'd1;
   localparam logic [1:0] REQ_GET    = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   // result status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_BADLEN = 3'd1;
   localparam logic [2:0] ST_EMPTY  = 3'd2;
   localparam logic [2:0] ST_FULL   = 3'd3;
   localparam logic [2:0] ST_SMALL  = 3'd4;

   // register selects (address bit 2)
   localparam logic REG_MAX_MSG_BYTES = 1'b0;
   localparam logic REG_ACTIVE_SLOTS  = 1'b1;

   // register reset values
   localparam logic [6:0] MAX_MSG_BYTES_RESET = 7'd64;
   localparam logic [4:0] ACTIVE_SLOTS_RESET  = 5'd16;

   typedef struct packed {
      logic [6:0] max_msg_bytes;
      logic [4:0] active_slots;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] data_word;
      logic        last_word;
      logic [6:0]  msg_len;
      logic [6:0]  buffer_size;
   } req_item_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic        out_last;
      logic [6:0]  out_len;
      logic [2:0]  status;
   } rsp_item_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_LEN   = 3'b010,
      S_WORDS = 3'b100
   } state_type;

   // keeps the bytes of a word that still belong to the message
   function automatic logic [31:0] byte_mask(input logic [6:0] have);
      logic [31:0] mask;
      if (have >= 7'd4) begin
         mask = '1;
      end else begin
         case (have[1:0])
            2'd1:    mask = 32'h0000_00ff;
            2'd2:    mask = 32'h0000_ffff;
            2'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'h0000_0000;
         endcase
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

// File: rtl/mrq_ram.sv
`default_nettype none

module mrq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port; read data holds when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/mrq_csr.sv
`default_nettype none

module mrq_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output      logic [31:0]       prdata,
   output      logic              pready,
   output      mrq_pkg::cfg_type  cfg
);
   import mrq_pkg::*;

   logic [6:0] max_bytes_ff, max_bytes_in;
   logic [4:0] slots_ff, slots_in;
   logic       wr_fire;

   assign pready  = 1'b1;
   assign wr_fire = psel && penable && pwrite && pready;

   // register writes in the access phase
   always_comb begin
      max_bytes_in = max_bytes_ff;
      slots_in     = slots_ff;
      if (wr_fire) begin
         if (paddr[2] == REG_ACTIVE_SLOTS) begin
            slots_in = pwdata[4:0];
         end else begin
            max_bytes_in = pwdata[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_MSG_BYTES_RESET;
         slots_ff     <= ACTIVE_SLOTS_RESET;
      end else begin
         max_bytes_ff <= max_bytes_in;
         slots_ff     <= slots_in;
      end
   end

   // read back
   always_comb begin
      if (paddr[2] == REG_MAX_MSG_BYTES) begin
         prdata = 32'(max_bytes_ff);
      end else begin
         prdata = 32'(slots_ff);
      end
   end

   assign cfg.max_msg_bytes = max_bytes_ff;
   assign cfg.active_slots  = slots_ff;

endmodule

`default_nettype wire

// File: rtl/message_ring_queue_with_urgent.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_ready   req_item_type
// rsp       out        rsp_valid/rsp_ready   rsp_item_type
// apb       in/out     psel/penable, pready  paddr, pwdata, prdata
//
// append, urgent and clear requests are answered from S_IDLE; a word is written
// to the slot memory in the cycle the request is accepted.
// a get is accepted, reads the length memory in S_LEN, reads the first word,
// then streams one word per cycle while rsp is not stalled.
// req_ready drops while a get streams; a stalled rsp holds the result
// register and the word read ahead of it. reset clears pointers, not memories.
`default_nettype none

module message_ring_queue_with_urgent #(
   parameter int SLOT_COUNT = 16,
   parameter int MAX_WORDS  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire mrq_pkg::req_item_type req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      mrq_pkg::rsp_item_type rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [2:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output      logic [31:0]           prdata,
   output      logic                  pready
);
   import mrq_pkg::*;

   localparam int SW     = $clog2(SLOT_COUNT);
   localparam int PW     = SW + 1;
   localparam int CW     = $clog2(SLOT_COUNT + 1);
   localparam int EW     = (CW > 5) ? CW : 5;
   localparam int IW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int OW     = $clog2(MAX_WORDS + 1);
   localparam int WDEPTH = SLOT_COUNT * MAX_WORDS;
   localparam int WAW    = $clog2(WDEPTH);
   localparam logic [8:0] CAP_BYTES = 9'(4 * MAX_WORDS);

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] p,
                                              input logic [CW-1:0] n);
      logic [PW-1:0] q;
      q = PW'(p) + PW'(1);
      return (q >= PW'(n)) ? '0 : SW'(q);
   endfunction

   cfg_type cfg;

   state_type    state_ff, state_in;
   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [OW-1:0] fo_ff, fo_in;
   logic [1:0]    fe_ff, fe_in;
   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_ff, out_in;
   logic [6:0]    buf_ff, buf_in;
   logic [6:0]    len_ff, len_in;
   logic [OW-1:0] rem_ff, rem_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [6:0]    left_ff, left_in;
   logic          pend_ff, pend_in;
   logic [6:0]    pend_left_ff, pend_left_in;
   logic          pend_last_ff, pend_last_in;

   logic [CW-1:0] eff_slots;
   logic [SW-1:0] head_dec;
   logic          out_free;
   logic          req_fire;
   logic          is_add;
   logic          urgent;
   logic [SW-1:0] add_slot;
   logic          fo_full;
   logic          q_full;
   logic [1:0]    fe_n;
   logic [OW-1:0] fo_n;
   logic [5:0]    need;
   logic          len_bad;
   logic [2:0]    add_status;
   logic          commit;
   logic          word_wr_en;
   logic [WAW-1:0] word_wr_addr;
   logic          word_rd_en;
   logic [WAW-1:0] word_rd_addr;
   logic [31:0]   word_rd_data;
   logic          len_rd_en;
   logic [6:0]    len_rd_data;
   logic [5:0]    rd_words;
   logic [OW-1:0] nw;
   logic          move;
   logic          issue;

   mrq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // slot count in use, clamped to 1..SLOT_COUNT
   always_comb begin
      if (cfg.active_slots == 5'd0) begin
         eff_slots = CW'(1);
      end else if (EW'(cfg.active_slots) > EW'(SLOT_COUNT)) begin
         eff_slots = CW'(SLOT_COUNT);
      end else begin
         eff_slots = CW'(cfg.active_slots);
      end
   end

   assign head_dec = (head_ff == '0) ? SW'(eff_slots - CW'(1)) : head_ff - SW'(1);

   // request handshake
   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   // add path: word store and message check
   assign is_add   = (req_data.req_type == REQ_APPEND) || (req_data.req_type == REQ_URGENT);
   assign urgent   = (req_data.req_type == REQ_URGENT);
   assign add_slot = urgent ? head_dec : tail_ff;
   assign fo_full  = (fo_ff >= OW'(MAX_WORDS));
   assign q_full   = (count_ff >= eff_slots);
   assign fo_n     = fo_full ? fo_ff : fo_ff + OW'(1);
   assign need     = 6'((8'(req_data.msg_len) + 8'd3) >> 2);

   always_comb begin
      if (fo_full) begin
         fe_n = ST_BADLEN[1:0];
      end else if (q_full && (fe_ff == 2'd0)) begin
         fe_n = ST_FULL[1:0];
      end else begin
         fe_n = fe_ff;
      end
   end

   assign len_bad = (req_data.msg_len == 7'd0)
                 || (9'(req_data.msg_len) > 9'(cfg.max_msg_bytes))
                 || (9'(req_data.msg_len) > CAP_BYTES)
                 || (8'(need) != 8'(fo_n));

   assign add_status = (fe_n != 2'd0) ? {1'b0, fe_n} : (len_bad ? ST_BADLEN : ST_OK);
   assign commit     = req_fire && is_add && req_data.last_word && (add_status == ST_OK);

   assign word_wr_en   = req_fire && is_add && !fo_full && !q_full && (fe_ff == 2'd0);
   assign word_wr_addr = WAW'(add_slot) * WAW'(MAX_WORDS) + WAW'(fo_ff);

   // get path: length read, then word stream with one word read ahead
   assign len_rd_en = req_fire && (req_data.req_type == REQ_GET) && (count_ff != '0);
   assign rd_words  = 6'((8'(len_rd_data) + 8'd3) >> 2);

   always_comb begin
      if (rd_words == 6'd0) begin
         nw = OW'(1);
      end else if (8'(rd_words) > 8'(MAX_WORDS)) begin
         nw = OW'(MAX_WORDS);
      end else begin
         nw = OW'(rd_words);
      end
   end

   assign move         = (state_ff == S_WORDS) && pend_ff && out_free;
   assign issue        = (state_ff == S_WORDS) && (rem_ff != '0) && (!pend_ff || move);
   assign word_rd_en   = issue;
   assign word_rd_addr = WAW'(head_ff) * WAW'(MAX_WORDS) + WAW'(idx_ff);

   mrq_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_word_ram (
      .clock   (clock),
      .wr_en   (word_wr_en),
      .wr_addr (word_wr_addr),
      .wr_data (req_data.data_word),
      .rd_en   (word_rd_en),
      .rd_addr (word_rd_addr),
      .rd_data (word_rd_data)
   );

   mrq_ram #(.WIDTH(7), .DEPTH(SLOT_COUNT)) u_len_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (add_slot),
      .wr_data (req_data.msg_len),
      .rd_en   (len_rd_en),
      .rd_addr (head_ff),
      .rd_data (len_rd_data)
   );

   // sequencer and queue state
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      fo_in        = fo_ff;
      fe_in        = fe_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      buf_in       = buf_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      pend_left_in = pend_left_ff;
      pend_last_in = pend_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_data.req_type)
                  REQ_APPEND, REQ_URGENT: begin
                     if (req_data.last_word) begin
                        fo_in        = '0;
                        fe_in        = 2'd0;
                        out_valid_in = 1'b1;
                        out_in       = '{32'd0, 1'b1, 7'd0, add_status};
                        if (add_status == ST_OK) begin
                           count_in = count_ff + CW'(1);
                           if (urgent) begin
                              head_in = add_slot;
                           end else begin
                              tail_in = slot_inc(tail_ff, eff_slots);
                           end
                        end
                     end else begin
                        fo_in = fo_n;
                        fe_in = fe_n;
                     end
                  end
                  REQ_GET: begin
                     buf_in = req_data.buffer_size;
                     if (count_ff == '0) begin
                        out_valid_in = 1'b1;
                        out_in       = '{32'd0, 1'b1, 7'd0, ST_EMPTY};
                     end else begin
                        state_in = S_LEN;
                     end
                  end
                  default: begin
                     head_in      = '0;
                     tail_in      = '0;
                     count_in     = '0;
                     fo_in        = '0;
                     fe_in        = 2'd0;
                     out_valid_in = 1'b1;
                     out_in       = '{32'd0, 1'b1, 7'd0, ST_OK};
                  end
               endcase
            end
         end
         S_LEN: begin
            if (out_free) begin
               if (buf_ff < len_rd_data) begin
                  out_valid_in = 1'b1;
                  out_in       = '{32'd0, 1'b1, len_rd_data, ST_SMALL};
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_WORDS;
                  len_in   = len_rd_data;
                  rem_in   = nw;
                  idx_in   = '0;
                  left_in  = len_rd_data;
                  pend_in  = 1'b0;
               end
            end
         end
         S_WORDS: begin
            if (move) begin
               out_valid_in = 1'b1;
               out_in       = '{word_rd_data & byte_mask(pend_left_ff), pend_last_ff,
                                len_ff, ST_OK};
               pend_in      = 1'b0;
               if (pend_last_ff) begin
                  state_in = S_IDLE;
                  head_in  = slot_inc(head_ff, eff_slots);
                  count_in = count_ff - CW'(1);
               end
            end
            if (issue) begin
               pend_in      = 1'b1;
               pend_left_in = left_ff;
               pend_last_in = (rem_ff == OW'(1));
               rem_in       = rem_ff - OW'(1);
               idx_in       = idx_ff + IW'(1);
               left_in      = (left_ff >= 7'd4) ? left_ff - 7'd4 : 7'd0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fo_ff        <= '0;
         fe_ff        <= 2'd0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rem_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fo_ff        <= fo_in;
         fe_ff        <= fe_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         rem_ff       <= rem_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_ff       <= out_in;
      buf_ff       <= buf_in;
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      left_ff      <= left_in;
      pend_left_ff <= pend_left_in;
      pend_last_ff <= pend_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// File: rtl/mrq_checker.sv
`default_nettype none
`include "message_ring_queue_with_urgent_macros.svh"

module mrq_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire mrq_pkg::rsp_item_type rsp_data
);
   import mrq_pkg::*;

   // a stalled result holds
   `MRQ_ASSERT_NEXT(rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp changed while stalled")

   // only a word run has results without the last mark, and those are ok
   `MRQ_ASSERT_NOW(run_status_ok, rsp_valid && !rsp_data.out_last, rsp_data.status == ST_OK, "non-final result with error status")

   // error results are single and carry no word
   `MRQ_ASSERT_NOW(err_single, rsp_valid && rsp_data.status != ST_OK, rsp_data.out_last && rsp_data.out_word == 32'd0, "error result malformed")

   // no new request is taken in the middle of a word run
   `MRQ_ASSERT_NOW(run_blocks_req, rsp_valid && !rsp_data.out_last, !req_ready, "request taken during a get run")

endmodule

bind message_ring_queue_with_urgent mrq_checker u_mrq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
